// ----- hw/rtl/wfsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfsa_pkg
// Shared types and constants for the worst-fit segment allocator.
// ----------------------------------------------------------------------------
package wfsa_pkg;

    localparam int HEAP_SIZE    = 4096;
    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_W       = 12;
    localparam int LEN_W        = 13;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_FIT      = 2'd1;
    localparam logic [1:0] ST_BAD_RELEASE = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL  = 2'd3;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              used;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } seg_t;

    typedef struct packed {
        logic              shift;
        seg_t              entry;
    } ring_ctl_t;

    typedef struct packed {
        logic              action;
        logic [12:0]       request_size;
        logic [11:0]       release_address;
    } req_t;

    typedef struct packed {
        logic [11:0]       block_address;
        logic [1:0]        status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_NEXT,
        S_WRITE
    } state_t;

endpackage

// ----- hw/rtl/wfsa_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfsa_cell
// One segment slot of the rotating segment ring.
// ----------------------------------------------------------------------------
module wfsa_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  wfsa_pkg::seg_t reset_entry,
    input  logic          shift,
    input  wfsa_pkg::seg_t din,
    output wfsa_pkg::seg_t dout
);
    import wfsa_pkg::*;

    seg_t seg_reg;
    seg_t seg_next;

    always_comb
    begin
        seg_next = shift ? din : seg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= reset_entry;
        end
        else
        begin
            seg_reg <= seg_next;
        end
    end

    assign dout = seg_reg;

endmodule

// ----- hw/rtl/wfsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfsa_ctrl
// Request sequencer at the ring tap: search passes and the rewrite pass.
// ----------------------------------------------------------------------------
module wfsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  wfsa_pkg::req_t    req,
    output logic              busy,
    output logic              done,
    output wfsa_pkg::rsp_t    result,
    input  wfsa_pkg::seg_t    tap,
    output wfsa_pkg::ring_ctl_t ring
);
    import wfsa_pkg::*;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    req_t                req_reg, req_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                found_reg, found_next;
    logic [ADDR_W-1:0]   bs_reg, bs_next;
    logic [LEN_W-1:0]    bl_reg, bl_next;
    logic                prev_reg, prev_next;
    logic [ADDR_W-1:0]   ps_reg, ps_next;
    logic [LEN_W-1:0]    pl_reg, pl_next;
    logic                nxt_reg, nxt_next;
    logic [LEN_W-1:0]    nl_reg, nl_next;
    logic                ins_reg, ins_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    logic                last;
    logic                split;
    logic [LEN_W-1:0]    addr_ext;
    logic [LEN_W-1:0]    end_addr;
    logic [LEN_W-1:0]    tap_end;
    logic                t_free;
    logic                t_used;
    seg_t                wb;

    assign last     = (cnt_reg == IDX_W'(MAX_SEGMENTS - 1));
    assign split    = (bl_reg > req_reg.request_size);
    assign addr_ext = {1'b0, req_reg.release_address};
    assign end_addr = addr_ext + bl_reg;
    assign tap_end  = {1'b0, tap.start} + tap.length;
    assign t_free   = tap.valid && !tap.used;
    assign t_used   = tap.valid && tap.used;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        count_next = count_reg;
        found_next = found_reg;
        bs_next    = bs_reg;
        bl_next    = bl_reg;
        prev_next  = prev_reg;
        ps_next    = ps_reg;
        pl_next    = pl_reg;
        nxt_next   = nxt_reg;
        nl_next    = nl_reg;
        ins_next   = ins_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        wb         = tap;
        ring.shift = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    prev_next  = 1'b0;
                    nxt_next   = 1'b0;
                    ins_next   = 1'b0;
                    if (req.action == ACT_ALLOC && req.request_size == '0)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{block_address: '0, status: ST_NO_FIT};
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
            end

            S_FIND:
            begin
                ring.shift = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (req_reg.action == ACT_ALLOC)
                begin
                    if (t_free && tap.length >= req_reg.request_size &&
                        (!found_reg || tap.length > bl_reg ||
                         (tap.length == bl_reg && tap.start < bs_reg)))
                    begin
                        found_next = 1'b1;
                        bs_next    = tap.start;
                        bl_next    = tap.length;
                    end
                end
                else
                begin
                    if (t_used && tap.start == req_reg.release_address)
                    begin
                        found_next = 1'b1;
                        bl_next    = tap.length;
                    end
                    if (t_free && tap_end == addr_ext)
                    begin
                        prev_next = 1'b1;
                        ps_next   = tap.start;
                        pl_next   = tap.length;
                    end
                end
                if (last)
                begin
                    cnt_next = '0;
                    if (!found_next)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        rsp_next   = '{block_address: '0,
                                       status: (req_reg.action == ACT_ALLOC) ?
                                               ST_NO_FIT : ST_BAD_RELEASE};
                    end
                    else if (req_reg.action == ACT_ALLOC)
                    begin
                        if (bl_next > req_reg.request_size &&
                            count_reg == CNT_W'(MAX_SEGMENTS))
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                            rsp_next   = '{block_address: '0, status: ST_TABLE_FULL};
                        end
                        else
                        begin
                            state_next = S_WRITE;
                        end
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end

            S_NEXT:
            begin
                ring.shift = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (t_free && {1'b0, tap.start} == end_addr)
                begin
                    nxt_next = 1'b1;
                    nl_next  = tap.length;
                end
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                ring.shift = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (req_reg.action == ACT_ALLOC)
                begin
                    if (t_free && tap.start == bs_reg)
                    begin
                        wb.used   = 1'b1;
                        wb.length = req_reg.request_size;
                    end
                    else if (split && !ins_reg && !tap.valid)
                    begin
                        wb.valid  = 1'b1;
                        wb.used   = 1'b0;
                        wb.start  = bs_reg + req_reg.request_size[ADDR_W-1:0];
                        wb.length = bl_reg - req_reg.request_size;
                        ins_next  = 1'b1;
                    end
                end
                else
                begin
                    if (t_used && tap.start == req_reg.release_address)
                    begin
                        if (prev_reg)
                        begin
                            wb.valid = 1'b0;
                        end
                        else
                        begin
                            wb.used   = 1'b0;
                            wb.length = bl_reg + (nxt_reg ? nl_reg : '0);
                        end
                    end
                    else if (prev_reg && t_free && tap.start == ps_reg)
                    begin
                        wb.length = pl_reg + bl_reg + (nxt_reg ? nl_reg : '0);
                    end
                    else if (nxt_reg && t_free && {1'b0, tap.start} == end_addr)
                    begin
                        wb.valid = 1'b0;
                    end
                end
                if (last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (req_reg.action == ACT_ALLOC)
                    begin
                        count_next = count_reg + CNT_W'(split);
                        rsp_next   = '{block_address: bs_reg, status: ST_OK};
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(prev_reg) - CNT_W'(nxt_reg);
                        rsp_next   = '{block_address: '0, status: ST_OK};
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ring.entry = wb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            count_reg <= CNT_W'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        found_reg <= found_next;
        bs_reg    <= bs_next;
        bl_reg    <= bl_next;
        prev_reg  <= prev_next;
        ps_reg    <= ps_next;
        pl_reg    <= pl_next;
        nxt_reg   <= nxt_next;
        nl_reg    <= nl_next;
        ins_reg   <= ins_next;
        rsp_reg   <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while a request is still in work");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status != ST_OK) |-> rsp_reg.block_address == '0)
        else $error("failed transfer carries a nonzero address");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count out of range");

    a_rewrite_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && last) |=> done_reg)
        else $error("rewrite pass ended without a result");

endmodule

// ----- hw/rtl/worst_fit_segment_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_segment_allocator
// Worst-fit heap allocator built on a rotating ring of segment cells.
// ----------------------------------------------------------------------------
// The segment table lives in a ring of MAX_SEGMENTS cells that rotates one
// place per cycle past a single compare tap while a request is in work, and
// stands still while idle. A request is taken when start is high and busy
// is low; its result appears on result with done high for one cycle, and
// must be taken then. A zero-size allocate answers without a pass over the
// ring; an allocate that fails answers after the search pass; a successful
// allocate after the search and rewrite passes; a failed release after the
// search pass and a good release after the search, next and rewrite passes.
// ----------------------------------------------------------------------------
module worst_fit_segment_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  wfsa_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output wfsa_pkg::rsp_t result
);
    import wfsa_pkg::*;

    seg_t      dout [MAX_SEGMENTS];
    seg_t      din  [MAX_SEGMENTS];
    ring_ctl_t ring;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            if (g == MAX_SEGMENTS - 1)
            begin : g_tail
                assign din[g] = ring.entry;
            end
            else
            begin : g_body
                assign din[g] = dout[g+1];
            end

            wfsa_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .reset_entry ((g == 0) ?
                              seg_t'{valid: 1'b1, used: 1'b0, start: '0,
                                     length: LEN_W'(HEAP_SIZE)} :
                              seg_t'('0)),
                .shift       (ring.shift),
                .din         (din[g]),
                .dout        (dout[g])
            );
        end
    endgenerate

    wfsa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result),
        .tap    (dout[0]),
        .ring   (ring)
    );

endmodule
